>>> design/swp_pkg.sv
// Shared types, codes and coil tables for the window stepper positioner.
// No dependencies; imported by every module of the block.
`default_nettype none

package swp_pkg;

  localparam int PCT_W = 7;
  localparam int CFG_W = 16;
  localparam int REG_IDX_W = 3;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CALIB = 2'd1;
  localparam logic [1:0] OP_OPEN  = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_CAL_CLOSE = 3'd1;
  localparam logic [2:0] MODE_CAL_OPEN  = 3'd2;
  localparam logic [2:0] MODE_OPENING   = 3'd3;
  localparam logic [2:0] MODE_CLOSING   = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_OPEN_FAST  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_SLOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLOSE_FAST = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLOSE_SLOW = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CALIB      = 3'd4;

  localparam logic [CFG_W-1:0] RST_OPEN_FAST  = 16'd5000;
  localparam logic [CFG_W-1:0] RST_OPEN_SLOW  = 16'd10000;
  localparam logic [CFG_W-1:0] RST_CLOSE_FAST = 16'd2500;
  localparam logic [CFG_W-1:0] RST_CLOSE_SLOW = 16'd5000;
  localparam logic [CFG_W-1:0] RST_CALIB      = 16'd5000;

  typedef struct packed {
    logic [CFG_W-1:0] open_fast;
    logic [CFG_W-1:0] open_slow;
    logic [CFG_W-1:0] close_fast;
    logic [CFG_W-1:0] close_slow;
    logic [CFG_W-1:0] calib;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [PCT_W-1:0] percent;
    logic             limit_a;
    logic             limit_b;
  } item_t;

  typedef struct packed {
    logic [3:0]       coils;
    logic             busy;
    logic [PCT_W-1:0] position;
    logic [15:0]      travel;
  } res_t;

  function automatic logic [3:0] coil_pattern(input logic closing, input logic [2:0] ph);
    logic [3:0] pat;
    if (closing) begin
      unique case (ph)
        3'd0: pat = 4'h1;
        3'd1: pat = 4'h3;
        3'd2: pat = 4'h2;
        3'd3: pat = 4'h6;
        3'd4: pat = 4'h4;
        3'd5: pat = 4'hC;
        3'd6: pat = 4'h8;
        default: pat = 4'h9;
      endcase
    end else begin
      unique case (ph)
        3'd0: pat = 4'h8;
        3'd1: pat = 4'hC;
        3'd2: pat = 4'h4;
        3'd3: pat = 4'h6;
        3'd4: pat = 4'h2;
        3'd5: pat = 4'h3;
        3'd6: pat = 4'h1;
        default: pat = 4'h9;
      endcase
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> design/swp_cfg.sv
// Dwell configuration registers of the window stepper positioner.
// Depends on swp_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module swp_cfg
  import swp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_fast  <= RST_OPEN_FAST;
      cfg.open_slow  <= RST_OPEN_SLOW;
      cfg.close_fast <= RST_CLOSE_FAST;
      cfg.close_slow <= RST_CLOSE_SLOW;
      cfg.calib      <= RST_CALIB;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OPEN_FAST:  cfg.open_fast  <= wr_data;
        REG_OPEN_SLOW:  cfg.open_slow  <= wr_data;
        REG_CLOSE_FAST: cfg.close_fast <= wr_data;
        REG_CLOSE_SLOW: cfg.close_slow <= wr_data;
        REG_CALIB:      cfg.calib      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/swp_core.sv
// Motion state of the window stepper positioner: mode, phase, dwell and cycle
// counters, position and travel. Depends on swp_pkg; produces the next result.
`default_nettype none

module swp_core
  import swp_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int DWELL_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  item_t     item,
  input  cfg_t      cfg,
  output res_t      res_next
);

  localparam int PW = COUNT_WIDTH + PCT_W;
  localparam int LW = (DWELL_WIDTH > CFG_W) ? DWELL_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [DWELL_WIDTH-1:0] DWL_MAX = '1;

  logic [2:0]             mode, mode_next;
  logic [2:0]             phase, phase_next;
  logic [DWELL_WIDTH-1:0] dwell, dwell_next;
  logic [COUNT_WIDTH-1:0] cycles, cycles_next;
  logic [PW-1:0]          prod, prod_next;
  logic [PCT_W-1:0]       pos, pos_next;
  logic [COUNT_WIDTH-1:0] travel, travel_next;
  logic [3:0]             coils, coils_next;

  logic                   idle;
  logic [PCT_W-1:0]       pct;
  logic [PCT_W:0]         pos_sum;
  logic [PW-1:0]          c100;
  logic [PW-1:0]          c125;
  logic                   move_done;
  logic                   slow;
  logic [CFG_W-1:0]       dwell_raw;
  logic [LW-1:0]          dwell_ext;
  logic [DWELL_WIDTH-1:0] dwell_lim;
  logic [2:0]             mode_b;
  logic                   start;
  logic [2:0]             start_mode;
  logic [PCT_W-1:0]       amount;

  assign idle = !(mode == MODE_CAL_CLOSE || mode == MODE_CAL_OPEN ||
                  mode == MODE_OPENING || mode == MODE_CLOSING);
  assign pct = (item.percent > PCT_FULL) ? PCT_FULL : item.percent;
  assign pos_sum = {1'b0, pos} + {1'b0, pct};

  // cycles >= prod/100 + 1 is the same as 100*cycles > prod
  assign c100 = (PW'(cycles) << 6) + (PW'(cycles) << 5) + (PW'(cycles) << 2);
  assign c125 = (PW'(cycles) << 7) - (PW'(cycles) << 1) - PW'(cycles);
  assign move_done = (c100 > prod) || (cycles == CNT_MAX);
  assign slow = (c125 >= prod);

  always_comb begin
    priority if (mode == MODE_OPENING) begin
      dwell_raw = slow ? cfg.open_slow : cfg.open_fast;
    end else if (mode == MODE_CLOSING) begin
      dwell_raw = slow ? cfg.close_slow : cfg.close_fast;
    end else begin
      dwell_raw = cfg.calib;
    end
  end

  assign dwell_ext = LW'(dwell_raw);
  assign dwell_lim = (dwell_ext > LW'(DWL_MAX)) ? DWL_MAX : dwell_ext[DWELL_WIDTH-1:0];

  always_comb begin
    mode_next   = mode;
    phase_next  = phase;
    dwell_next  = dwell;
    cycles_next = cycles;
    prod_next   = prod;
    pos_next    = pos;
    travel_next = travel;
    coils_next  = coils;
    mode_b      = mode;
    start       = 1'b0;
    start_mode  = MODE_OPENING;
    amount      = '0;

    if (item.op == OP_TICK) begin
      if (!idle) begin
        if (dwell == '0) begin
          if (mode == MODE_CAL_CLOSE && !item.limit_a) begin
            mode_b = MODE_CAL_OPEN;
          end
          if (mode_b == MODE_CAL_OPEN && !item.limit_b) begin
            mode_next = MODE_IDLE;
            pos_next  = PCT_FULL;
          end else if ((mode_b == MODE_OPENING || mode_b == MODE_CLOSING) && move_done) begin
            mode_next = MODE_IDLE;
          end else begin
            mode_next  = mode_b;
            phase_next = 3'd0;
            coils_next = coil_pattern(mode_b == MODE_CAL_CLOSE || mode_b == MODE_CLOSING,
                                      3'd0);
            dwell_next = DWELL_WIDTH'(1);
          end
        end else if (dwell < dwell_lim) begin
          dwell_next = dwell + DWELL_WIDTH'(1);
        end else if (phase == 3'd7) begin
          phase_next = 3'd0;
          dwell_next = '0;
          if (mode == MODE_CAL_OPEN) begin
            if (travel != CNT_MAX) travel_next = travel + COUNT_WIDTH'(1);
          end else if (mode == MODE_OPENING || mode == MODE_CLOSING) begin
            if (cycles != CNT_MAX) cycles_next = cycles + COUNT_WIDTH'(1);
          end
        end else begin
          phase_next = phase + 3'd1;
          coils_next = coil_pattern(mode == MODE_CAL_CLOSE || mode == MODE_CLOSING,
                                    phase + 3'd1);
          dwell_next = DWELL_WIDTH'(1);
        end
      end
    end else if (idle) begin
      unique case (item.op)
        OP_CALIB: begin
          mode_next   = MODE_CAL_CLOSE;
          phase_next  = 3'd0;
          dwell_next  = '0;
          cycles_next = '0;
          travel_next = '0;
        end
        OP_OPEN: begin
          start_mode = MODE_OPENING;
          if (pos_sum < {1'b0, PCT_FULL}) begin
            pos_next = pos_sum[PCT_W-1:0];
            amount   = pct;
            start    = 1'b1;
          end else if (pos != PCT_FULL) begin
            pos_next = PCT_FULL;
            amount   = PCT_FULL - pos;
            start    = 1'b1;
          end
        end
        OP_CLOSE: begin
          start_mode = MODE_CLOSING;
          if (pos > pct) begin
            pos_next = pos - pct;
            amount   = pct;
            start    = 1'b1;
          end else if (pos != '0) begin
            pos_next = '0;
            amount   = pos;
            start    = 1'b1;
          end
        end
        default: ;
      endcase
      if (start) begin
        mode_next   = start_mode;
        prod_next   = PW'(amount) * PW'(travel);
        cycles_next = '0;
        phase_next  = 3'd0;
        dwell_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_CAL_CLOSE;
      phase  <= '0;
      dwell  <= '0;
      cycles <= '0;
      prod   <= '0;
      pos    <= '0;
      travel <= '0;
      coils  <= '0;
    end else if (go) begin
      mode   <= mode_next;
      phase  <= phase_next;
      dwell  <= dwell_next;
      cycles <= cycles_next;
      prod   <= prod_next;
      pos    <= pos_next;
      travel <= travel_next;
      coils  <= coils_next;
    end
  end

  assign res_next.coils    = coils_next;
  assign res_next.busy     = (mode_next == MODE_CAL_CLOSE || mode_next == MODE_CAL_OPEN ||
                              mode_next == MODE_OPENING || mode_next == MODE_CLOSING);
  assign res_next.position = pos_next;
  assign res_next.travel   = 16'(travel_next);

endmodule

`default_nettype wire

>>> design/stepper_window_positioner.sv
// Top level of the half-step window stepper positioner: input register,
// result register and handshakes. Depends on swp_pkg, swp_cfg and swp_core.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   in       | in_valid/in_stall  | op, percent, limit_a, limit_b
//   out      | out_valid/out_stall| coils, busy_res, position, travel_steps
//   config   | wr_en              | wr_index, wr_data
//
// One request enters per cycle while the result is not stalled; it passes the input
// register and the result register, with the state update between them.
// Reset starts a calibration closing run with all coils off and default dwells.
// A stalled result holds the state update; the input register still takes one
// more request while the result waits, if it holds none.
`default_nettype none

module stepper_window_positioner
  import swp_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int DWELL_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           op,
  input  wire logic [PCT_W-1:0]     percent,
  input  wire logic                 limit_a,
  input  wire logic                 limit_b,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [3:0]                coils,
  output logic                      busy_res,
  output logic [PCT_W-1:0]          position,
  output logic [15:0]               travel_steps,
  input  wire logic                 wr_en,
  input  wire logic [REG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data
);

  cfg_t  cfg;
  item_t item;
  res_t  res_next;
  logic  item_valid;
  logic  advance;
  logic  go;
  logic  take;

  assign advance  = !out_valid || !out_stall;
  assign go       = item_valid && advance;
  assign in_stall = item_valid && !advance;
  assign take     = in_valid && !in_stall;

  swp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  swp_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .DWELL_WIDTH (DWELL_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (item),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        item_valid <= 1'b1;
      end else if (go) begin
        item_valid <= 1'b0;
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.op      <= op;
      item.percent <= percent;
      item.limit_a <= limit_a;
      item.limit_b <= limit_b;
    end
    if (go) begin
      coils        <= res_next.coils;
      busy_res     <= res_next.busy;
      position     <= res_next.position;
      travel_steps <= res_next.travel;
    end
  end

endmodule

`default_nettype wire
